// File: hw/rtl/ipcmb_pkg.sv
// ---------------------------------------------------------------------------
// IPC mailbox package
// Shared item layouts, command and status codes and the state type of the
// multi-endpoint mailbox.
// ---------------------------------------------------------------------------
`default_nettype none

package ipcmb_pkg;

  // Command codes carried in the command field of an input item.
  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_OWNER  = 2'd1,
    CMD_SEND   = 2'd2,
    CMD_RECV   = 2'd3
  } cmd_e;

  // Status codes returned in each result item.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_PERM    = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // Widths of the stream data buses.
  localparam int unsigned InBits    = 66;
  localparam int unsigned InBusBits = 72;
  localparam int unsigned OutBits   = 80;

  // One message as it sits in the message store: source above payload.
  localparam int unsigned MsgBits = 36;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [31:0] message_payload;
    logic [7:0]  message_source;
    logic [7:0]  endpoint;
    logic [15:0] context_id;
    cmd_e        command;
  } in_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [15:0] wake_context;
    logic        wake_valid;
    logic [31:0] msg_payload;
    logic [3:0]  msg_destination;
    logic [3:0]  msg_source;
    logic [15:0] owner_context;
    logic [3:0]  created_endpoint;
    logic [2:0]  status;
  } res_t;

  // Write request from the control logic to the endpoint table.
  typedef struct packed {
    logic claim;   // mark the entry in use and write its owner
    logic ptr_we;  // write the queue pointers of the entry
  } tbl_wr_t;

  // Command sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_FETCH,
    S_HOLD
  } state_e;

endpackage

`default_nettype wire

// File: hw/rtl/ipcmb_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module ipcmb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/ipcmb_ep_table.sv
// ---------------------------------------------------------------------------
// IPC mailbox endpoint table
// In-use marks in flip-flops with a lowest-free search, owner contexts in
// two RAM copies (target and source reads) and queue pointers in one RAM.
// ---------------------------------------------------------------------------
`default_nettype none

module ipcmb_ep_table #(
  parameter int unsigned ENDPOINTS = 16,
  parameter int unsigned PTRW      = 10,
  parameter int unsigned EW        = $clog2(ENDPOINTS)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Read request, issued when an item is accepted.
  input  wire logic                     rd_en_i,
  input  wire logic [EW-1:0]            rd_ep_i,
  input  wire logic [EW-1:0]            rd_src_i,
  // In-use lookup of the item being worked on.
  input  wire logic [EW-1:0]            lk_ep_i,
  input  wire logic [EW-1:0]            lk_src_i,
  output logic                          tgt_used_o,
  output logic                          src_used_o,
  output logic [15:0]                   tgt_owner_o,
  output logic [15:0]                   src_owner_o,
  output logic [PTRW-1:0]               ptr_o,
  output logic                          free_found_o,
  output logic [EW-1:0]                 free_idx_o,
  // Write request.
  input  ipcmb_pkg::tbl_wr_t            wr_i,
  input  wire logic [EW-1:0]            wr_idx_i,
  input  wire logic [15:0]              wr_owner_i,
  input  wire logic [PTRW-1:0]          wr_ptr_i
);

  import ipcmb_pkg::*;

  logic [ENDPOINTS-1:0] used_q;
  logic [ENDPOINTS-1:0] used_d;

  // In-use marks: cleared by reset, set by a claim.
  always_comb begin
    used_d = used_q;
    if (wr_i.claim) begin
      used_d[wr_idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  assign tgt_used_o = used_q[lk_ep_i];
  assign src_used_o = used_q[lk_src_i];

  // Lowest free entry.
  always_comb begin
    free_found_o = 1'b0;
    free_idx_o   = '0;
    for (int i = ENDPOINTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found_o = 1'b1;
        free_idx_o   = EW'(i);
      end
    end
  end

  // Owner copy read at the target endpoint.
  ipcmb_ram #(
    .WIDTH (16),
    .DEPTH (ENDPOINTS),
    .AW    (EW)
  ) u_owner_tgt (
    .clk_i   (clk_i),
    .we_i    (wr_i.claim),
    .waddr_i (wr_idx_i),
    .wdata_i (wr_owner_i),
    .re_i    (rd_en_i),
    .raddr_i (rd_ep_i),
    .rdata_o (tgt_owner_o)
  );

  // Owner copy read at the stated source endpoint.
  ipcmb_ram #(
    .WIDTH (16),
    .DEPTH (ENDPOINTS),
    .AW    (EW)
  ) u_owner_src (
    .clk_i   (clk_i),
    .we_i    (wr_i.claim),
    .waddr_i (wr_idx_i),
    .wdata_i (wr_owner_i),
    .re_i    (rd_en_i),
    .raddr_i (rd_src_i),
    .rdata_o (src_owner_o)
  );

  // Queue pointers {count, tail, head} of each endpoint.
  ipcmb_ram #(
    .WIDTH (PTRW),
    .DEPTH (ENDPOINTS),
    .AW    (EW)
  ) u_ptr (
    .clk_i   (clk_i),
    .we_i    (wr_i.ptr_we),
    .waddr_i (wr_idx_i),
    .wdata_i (wr_ptr_i),
    .re_i    (rd_en_i),
    .raddr_i (rd_ep_i),
    .rdata_o (ptr_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ipc_mailbox_endpoints_unit.sv
// ---------------------------------------------------------------------------
// IPC mailbox with multiple endpoints
// Endpoint table plus per-endpoint ring queues of messages; executes create,
// owner query, send and receive commands, one result item per command.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake                       Contents
// s_axis    in         s_axis_tvalid_i/s_axis_tready_o  one command
// m_axis    out        m_axis_tvalid_o/m_axis_tready_i  one result
// cfg       in         cfg_we_i                          kernel context id
//
// Create, owner query and send register their result after the endpoint
// table read; a receive that dequeues reads the message store before its result.
// The next item can be accepted in the cycle after its result enters the
// output register.
// Reset clears the in-use marks at once; there is no clearing pass.
// A stalled output holds one result in the output register and one in a
// hold register; the block takes no new item until its result is placed.
`default_nettype none

module ipc_mailbox_endpoints_unit #(
  parameter int unsigned ENDPOINTS   = 16,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Fields from bit 0: command[1:0], context_id[17:2], endpoint[25:18],
  // message_source[33:26], message_payload[65:34], zero fill[71:66].
  input  wire logic [71:0] s_axis_tdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // Fields from bit 0: status[2:0], created_endpoint[6:3],
  // owner_context[22:7], msg_source[26:23], msg_destination[30:27],
  // msg_payload[62:31], wake_valid[63], wake_context[79:64].
  output logic [79:0]      m_axis_tdata_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  import ipcmb_pkg::*;

  localparam int unsigned EW   = $clog2(ENDPOINTS);
  localparam int unsigned PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PTRW = CW + 2 * PW;
  localparam int unsigned SD   = ENDPOINTS * QUEUE_DEPTH;
  localparam int unsigned SAW  = $clog2(SD);

  state_e state_q, state_d;
  logic [15:0] kern_q;
  in_t  req_q;
  res_t hold_q;
  res_t out_q, out_d;
  logic out_vld_q, out_vld_d;

  in_t  in_w;
  logic accept;
  logic out_free;

  // Endpoint table signals.
  tbl_wr_t         tbl_wr;
  logic            tgt_used, src_used;
  logic [15:0]     tgt_owner, src_owner;
  logic [PTRW-1:0] ptr_rd, wr_ptr;
  logic            free_found;
  logic [EW-1:0]   free_idx, wr_idx, ep_idx, src_idx;
  logic [15:0]     wr_owner;

  // Decoded pointers.
  logic [PW-1:0] head, tail, head_nx, tail_nx;
  logic [CW-1:0] cnt;

  // Decision of the lookup cycle.
  res_t            res_lk, res_fetch, res_now;
  logic            go_fetch;
  tbl_wr_t         wr_lk;
  logic            st_we_lk, st_re_lk;
  logic            finish;
  logic            tgt_ok, src_ok, kern;
  logic [7:0]      free_idx8;
  logic [SAW-1:0]  slot_base, slot_tail, slot_head;
  logic [MsgBits-1:0] st_rdata;

  assign in_w     = in_t'(s_axis_tdata_i[InBits-1:0]);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;

  // Kernel context register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q <= '0;
    end else if (cfg_we_i) begin
      kern_q <= cfg_wdata_i;
    end
  end

  // Capture of the accepted item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_w;
    end
  end

  assign ep_idx  = req_q.endpoint[EW-1:0];
  assign src_idx = req_q.message_source[EW-1:0];

  ipcmb_ep_table #(
    .ENDPOINTS (ENDPOINTS),
    .PTRW      (PTRW),
    .EW        (EW)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (accept),
    .rd_ep_i      (in_w.endpoint[EW-1:0]),
    .rd_src_i     (in_w.message_source[EW-1:0]),
    .lk_ep_i      (ep_idx),
    .lk_src_i     (src_idx),
    .tgt_used_o   (tgt_used),
    .src_used_o   (src_used),
    .tgt_owner_o  (tgt_owner),
    .src_owner_o  (src_owner),
    .ptr_o        (ptr_rd),
    .free_found_o (free_found),
    .free_idx_o   (free_idx),
    .wr_i         (tbl_wr),
    .wr_idx_i     (wr_idx),
    .wr_owner_i   (wr_owner),
    .wr_ptr_i     (wr_ptr)
  );

  // Pointer fields and their ring increments.
  assign head    = ptr_rd[PW-1:0];
  assign tail    = ptr_rd[2*PW-1:PW];
  assign cnt     = ptr_rd[PTRW-1:2*PW];
  assign head_nx = (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + PW'(1);
  assign tail_nx = (tail == PW'(QUEUE_DEPTH - 1)) ? '0 : tail + PW'(1);

  // Message store addresses of the target queue.
  assign slot_base = SAW'(ep_idx) * SAW'(QUEUE_DEPTH);
  assign slot_tail = slot_base + SAW'(tail);
  assign slot_head = slot_base + SAW'(head);

  // Validity and permission checks.
  assign kern      = (req_q.context_id == kern_q);
  assign tgt_ok    = ({1'b0, req_q.endpoint} < 9'(ENDPOINTS)) && tgt_used;
  assign src_ok    = ({1'b0, req_q.message_source} < 9'(ENDPOINTS)) && src_used;
  assign free_idx8 = 8'(free_idx);

  // Command decision in the lookup cycle.
  always_comb begin
    res_lk   = '0;
    go_fetch = 1'b0;
    wr_lk    = '0;
    wr_idx   = ep_idx;
    wr_owner = req_q.context_id;
    wr_ptr   = ptr_rd;
    st_we_lk = 1'b0;
    st_re_lk = 1'b0;
    case (req_q.command)
      CMD_CREATE: begin
        if (free_found) begin
          res_lk.status           = ST_OK;
          res_lk.created_endpoint = free_idx8[3:0];
          wr_lk.claim             = 1'b1;
          wr_lk.ptr_we            = 1'b1;
          wr_idx                  = free_idx;
          wr_ptr                  = '0;
        end else begin
          res_lk.status = ST_FULL;
        end
      end
      CMD_OWNER: begin
        if (!tgt_ok) begin
          res_lk.status = ST_INVALID;
        end else begin
          res_lk.status        = ST_OK;
          res_lk.owner_context = tgt_owner;
        end
      end
      CMD_SEND: begin
        if (!tgt_ok) begin
          res_lk.status = ST_INVALID;
        end else if (!kern && (!src_ok || src_owner != req_q.context_id)) begin
          res_lk.status = ST_PERM;
        end else if (cnt >= CW'(QUEUE_DEPTH)) begin
          res_lk.status = ST_FULL;
        end else begin
          res_lk.status       = ST_OK;
          res_lk.wake_valid   = 1'b1;
          res_lk.wake_context = tgt_owner;
          st_we_lk            = 1'b1;
          wr_lk.ptr_we        = 1'b1;
          wr_ptr              = {cnt + CW'(1), tail_nx, head};
        end
      end
      CMD_RECV: begin
        if (!tgt_ok) begin
          res_lk.status = ST_INVALID;
        end else if (!kern && tgt_owner != req_q.context_id) begin
          res_lk.status = ST_PERM;
        end else if (cnt == '0) begin
          res_lk.status = ST_EMPTY;
        end else begin
          go_fetch     = 1'b1;
          st_re_lk     = 1'b1;
          wr_lk.ptr_we = 1'b1;
          wr_ptr       = {cnt - CW'(1), tail, head_nx};
        end
      end
      default: begin
        res_lk = '0;
      end
    endcase
  end

  assign tbl_wr = (state_q == S_LOOKUP) ? wr_lk : '0;

  // Message store: payload in the low bits, 4-bit source above.
  ipcmb_ram #(
    .WIDTH (MsgBits),
    .DEPTH (SD),
    .AW    (SAW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_LOOKUP) && st_we_lk),
    .waddr_i (slot_tail),
    .wdata_i ({req_q.message_source[3:0], req_q.message_payload}),
    .re_i    ((state_q == S_LOOKUP) && st_re_lk),
    .raddr_i (slot_head),
    .rdata_o (st_rdata)
  );

  // Result of a receive once the message has been read.
  always_comb begin
    res_fetch                 = '0;
    res_fetch.status          = ST_OK;
    res_fetch.msg_source      = st_rdata[MsgBits-1:32];
    res_fetch.msg_destination = req_q.endpoint[3:0];
    res_fetch.msg_payload     = st_rdata[31:0];
  end

  assign res_now = (state_q == S_FETCH) ? res_fetch : res_lk;
  assign finish  = ((state_q == S_LOOKUP) && !go_fetch) || (state_q == S_FETCH);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (go_fetch) begin
          state_d = S_FETCH;
        end else if (out_free) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_FETCH: begin
        state_d = out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: input ready and output register load.
  always_comb begin
    s_axis_tready_o = (state_q == S_IDLE);
    out_d           = out_q;
    out_vld_d       = out_vld_q && !m_axis_tready_i;
    if (finish && out_free) begin
      out_d     = res_now;
      out_vld_d = 1'b1;
    end else if ((state_q == S_HOLD) && out_free) begin
      out_d     = hold_q;
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Output and hold registers.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (finish && !out_free) begin
      hold_q <= res_now;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/ipcmb_sva.sv
// ---------------------------------------------------------------------------
// IPC mailbox port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ipcmb_sva (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic [71:0] s_axis_tdata_i,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [79:0] m_axis_tdata_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic        cfg_we_i,
  input wire logic [15:0] cfg_wdata_i
);

  import ipcmb_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Only one command is worked on at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("item accepted while another is at work");

  // A wake is only signalled by a successful send.
  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[63] |-> m_axis_tdata_o[2:0] == ST_OK)
    else $error("wake with error status");

  // A failed command returns no other field.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2:0] != ST_OK |-> m_axis_tdata_o[79:3] == '0)
    else $error("failed command carries data");

  // The status is always one of the defined codes.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[2:0] <= ST_FULL)
    else $error("undefined status code");

endmodule

bind ipc_mailbox_endpoints_unit ipcmb_sva u_ipcmb_sva (.*);

`default_nettype wire

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// IPC mailbox endpoints testbench
// Drives command items into the mailbox and checks every result item against
// a behavioral model of the endpoint table and its message queues. A short
// directed sequence covers invalid targets, create and query, the ownership
// rules and a full queue. Random traffic then runs under several kernel
// context settings, with random idling on both streams and one long output
// stall.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ipcmb_pkg::*;

  localparam int EP_COUNT    = 16;
  localparam int DEPTH       = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_LIMIT = 40;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic [71:0] s_axis_tdata_i  = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [79:0] m_axis_tdata_o;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [15:0] cfg_wdata_i     = '0;

  // Model of the mailbox state.
  logic [15:0] kernel_ctx = '0;
  logic        ep_used [EP_COUNT];
  logic [15:0] ep_owner [EP_COUNT];
  int          q_head [EP_COUNT];
  int          q_tail [EP_COUNT];
  int          q_fill [EP_COUNT];
  logic [31:0] msg_payload_mem [EP_COUNT*DEPTH];
  logic [3:0]  msg_source_mem [EP_COUNT*DEPTH];

  res_t pending_replies[$];
  int   mismatches   = 0;
  int   replies_seen = 0;
  bit   tx_idle_on   = 1'b1;
  bit   rx_idle_on   = 1'b1;
  int   hold_req     = 0;
  int   hold_seen    = 0;
  int   stall_left   = 0;

  ipc_mailbox_endpoints_unit #(
    .ENDPOINTS  (EP_COUNT),
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Executes one command on the model and returns the result it must give.
  function automatic res_t predict_reply(input in_t it);
    res_t r;
    int   e;
    int   s;
    int   slot;
    logic found;
    r     = '0;
    e     = it.endpoint;
    s     = it.message_source;
    found = 1'b0;
    if (it.command == CMD_CREATE) begin
      r.status = ST_FULL;
      for (int i = 0; i < EP_COUNT; i++) begin
        if (!found && !ep_used[i]) begin
          found              = 1'b1;
          ep_used[i]         = 1'b1;
          ep_owner[i]        = it.context_id;
          q_head[i]          = 0;
          q_tail[i]          = 0;
          q_fill[i]          = 0;
          r.status           = ST_OK;
          r.created_endpoint = 4'(i);
        end
      end
    end else if (e >= EP_COUNT || !ep_used[e]) begin
      r.status = ST_INVALID;
    end else if (it.command == CMD_OWNER) begin
      r.status        = ST_OK;
      r.owner_context = ep_owner[e];
    end else if (it.command == CMD_SEND) begin
      if (it.context_id != kernel_ctx &&
          (s >= EP_COUNT || !ep_used[s] || ep_owner[s] != it.context_id)) begin
        r.status = ST_PERM;
      end else if (q_fill[e] >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot                  = e * DEPTH + q_tail[e];
        msg_payload_mem[slot] = it.message_payload;
        msg_source_mem[slot]  = it.message_source[3:0];
        q_tail[e]             = (q_tail[e] + 1) % DEPTH;
        q_fill[e]++;
        r.status       = ST_OK;
        r.wake_valid   = 1'b1;
        r.wake_context = ep_owner[e];
      end
    end else begin
      if (it.context_id != kernel_ctx && ep_owner[e] != it.context_id) begin
        r.status = ST_PERM;
      end else if (q_fill[e] == 0) begin
        r.status = ST_EMPTY;
      end else begin
        slot              = e * DEPTH + q_head[e];
        r.status          = ST_OK;
        r.msg_source      = msg_source_mem[slot];
        r.msg_destination = 4'(e);
        r.msg_payload     = msg_payload_mem[slot];
        q_head[e]         = (q_head[e] + 1) % DEPTH;
        q_fill[e]--;
      end
    end
    return r;
  endfunction

  function automatic in_t make_cmd(input cmd_e c, input logic [15:0] ctx,
                                   input logic [7:0] ep, input logic [7:0] src,
                                   input logic [31:0] payload);
    in_t it;
    it.command         = c;
    it.context_id      = ctx;
    it.endpoint        = ep;
    it.message_source  = src;
    it.message_payload = payload;
    return it;
  endfunction

  // Random command. Most sends and receives carry a context that passes the
  // ownership checks so that messages actually flow; the rest is noise.
  function automatic in_t next_random_command();
    in_t it;
    int  roll;
    int  e;
    int  s;
    it.context_id      = 16'($urandom);
    it.endpoint        = ($urandom_range(9) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(EP_COUNT - 1));
    it.message_source  = ($urandom_range(6) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(EP_COUNT - 1));
    it.message_payload = $urandom;
    e    = it.endpoint;
    s    = it.message_source;
    roll = $urandom_range(99);
    if (roll < 6) begin
      it.command = CMD_CREATE;
      case ($urandom_range(3))
        0:       it.context_id = 16'h1234;
        1:       it.context_id = 16'hABCD;
        2:       it.context_id = kernel_ctx;
        default: it.context_id = 16'($urandom);
      endcase
    end else if (roll < 15) begin
      it.command = CMD_OWNER;
    end else if (roll < 60) begin
      it.command = CMD_SEND;
      if ($urandom_range(9) < 8 && s < EP_COUNT && ep_used[s]) begin
        it.context_id = ep_owner[s];
      end else if ($urandom_range(1) == 1) begin
        it.context_id = kernel_ctx;
      end
    end else begin
      it.command = CMD_RECV;
      if ($urandom_range(9) < 8 && e < EP_COUNT && ep_used[e]) begin
        it.context_id = ep_owner[e];
      end else if ($urandom_range(1) == 1) begin
        it.context_id = kernel_ctx;
      end
    end
    return it;
  endfunction

  // Offers one item, with random idle cycles before it while idling is on, and
  // records the expected result once the block accepts it. Valid stays high afterwards.
  task automatic send_item(input in_t it);
    if (tx_idle_on) begin
      while ($urandom_range(99) < 26) begin
        s_axis_tvalid_i <= 1'b0;
        s_axis_tdata_i  <= {8'($urandom), $urandom, $urandom};
        @(posedge clk_i);
      end
    end
    s_axis_tdata_i  <= {6'b0, it};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_replies.push_back(predict_reply(it));
  endtask

  // Stops sending and waits until every expected result has arrived, then
  // lets the longest command latency pass.
  task automatic wait_for_replies();
    s_axis_tvalid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_kernel_context(input logic [15:0] value);
    wait_for_replies();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    kernel_ctx = value;
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("mismatch at result %0d: %s", replies_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  // Checks each accepted result and drives the output ready, including the
  // long hold-off requested by the stall test.
  always @(posedge clk_i) begin : reply_check
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = res_t'(m_axis_tdata_o);
      if (pending_replies.size() == 0) begin
        report_mismatch("result item with no command pending");
      end else begin
        want = pending_replies.pop_front();
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("created_endpoint", 32'(got.created_endpoint),
                    32'(want.created_endpoint));
        check_field("owner_context", 32'(got.owner_context), 32'(want.owner_context));
        check_field("msg_source", 32'(got.msg_source), 32'(want.msg_source));
        check_field("msg_destination", 32'(got.msg_destination),
                    32'(want.msg_destination));
        check_field("msg_payload", got.msg_payload, want.msg_payload);
        check_field("wake_valid", 32'(got.wake_valid), 32'(want.wake_valid));
        check_field("wake_context", 32'(got.wake_context), 32'(want.wake_context));
      end
      replies_seen++;
    end
    if (hold_req != hold_seen) begin
      hold_seen       <= hold_req;
      stall_left      <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !(rx_idle_on && $urandom_range(99) < 26);
    end
  end

  // Commands on endpoints that do not exist or are not in use yet.
  task automatic test_invalid_targets();
    send_item(make_cmd(CMD_OWNER, 16'h1234, 8'd0, 8'd0, 32'h0));
    send_item(make_cmd(CMD_SEND, 16'hFFFF, 8'd200, 8'd0, 32'h5A5A5A5A));
    send_item(make_cmd(CMD_RECV, 16'hFFFF, 8'd255, 8'd255, 32'h0));
  endtask

  task automatic test_create_and_query();
    send_item(make_cmd(CMD_CREATE, 16'h1234, 8'd0, 8'd0, 32'h0));
    send_item(make_cmd(CMD_CREATE, 16'hABCD, 8'd0, 8'd0, 32'h0));
    send_item(make_cmd(CMD_CREATE, 16'h0000, 8'd0, 8'd0, 32'h0));
    send_item(make_cmd(CMD_OWNER, 16'h0000, 8'd1, 8'd0, 32'h0));
    send_item(make_cmd(CMD_OWNER, 16'h0000, 8'd16, 8'd0, 32'h0));
  endtask

  // Ownership checks on send and receive, kernel bypass and source truncation.
  task automatic test_ownership_rules();
    send_item(make_cmd(CMD_RECV, 16'h1234, 8'd0, 8'd0, 32'h0));
    send_item(make_cmd(CMD_SEND, 16'hABCD, 8'd0, 8'd1, 32'hFFFFFFFF));
    send_item(make_cmd(CMD_SEND, 16'hABCD, 8'd0, 8'd0, 32'h11111111));
    send_item(make_cmd(CMD_SEND, 16'h1234, 8'd0, 8'd200, 32'h22222222));
    send_item(make_cmd(CMD_SEND, 16'h1234, 8'd0, 8'd5, 32'h33333333));
    send_item(make_cmd(CMD_SEND, 16'hFFFF, 8'd0, 8'hFF, 32'h00000000));
    send_item(make_cmd(CMD_RECV, 16'hABCD, 8'd0, 8'd0, 32'h0));
    send_item(make_cmd(CMD_RECV, 16'h1234, 8'd0, 8'd0, 32'h0));
    send_item(make_cmd(CMD_RECV, 16'hFFFF, 8'd0, 8'd0, 32'h0));
  endtask

  // One send more than the queue holds.
  task automatic test_queue_full();
    for (int i = 0; i <= DEPTH; i++) begin
      send_item(make_cmd(CMD_SEND, 16'hABCD, 8'd1, 8'd1, $urandom));
    end
  endtask

  // Issues one create more than the table has endpoints, so every remaining endpoint is claimed.
  task automatic test_endpoint_exhaustion();
    for (int i = 0; i <= EP_COUNT; i++) begin
      send_item(make_cmd(CMD_CREATE, 16'($urandom), 8'($urandom), 8'($urandom), $urandom));
    end
  endtask

  task automatic test_random_traffic(input int count, input logic [15:0] kctx,
                                     input bit idling);
    set_kernel_context(kctx);
    tx_idle_on = idling;
    rx_idle_on = idling;
    repeat (count) send_item(next_random_command());
    wait_for_replies();
  endtask

  // The receiver holds off while the sender keeps offering items, so the
  // block fills up and stops taking input.
  task automatic test_output_stall();
    wait_for_replies();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    hold_req <= hold_req + 1;
    repeat (40) send_item(next_random_command());
    wait_for_replies();
  endtask

  initial begin
    for (int i = 0; i < EP_COUNT; i++) begin
      ep_used[i]  = 1'b0;
      ep_owner[i] = '0;
      q_head[i]   = 0;
      q_tail[i]   = 0;
      q_fill[i]   = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_kernel_context(16'hFFFF);
    test_invalid_targets();
    test_create_and_query();
    test_ownership_rules();
    test_queue_full();
    test_random_traffic(330, 16'h0000, 1'b1);
    test_endpoint_exhaustion();
    test_random_traffic(330, 16'hFFFF, 1'b0);
    test_output_stall();
    test_random_traffic(330, ep_owner[3], 1'b1);
    test_random_traffic(300, 16'($urandom), 1'b1);
    wait_for_replies();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
